/* hdl/rlsd_pkg.sv */
// rlsd_pkg: shared types and constants for the run-length skip decoder.
// Holds item kind codes, the default sizes and the result record type.
// No dependencies.
package rlsd_pkg;

	localparam int MAX_RUNS_DEF   = 512;
	localparam int COUNT_BITS_DEF = 32;

	localparam int FIELD_BITS = 32;

	localparam logic [1:0] KIND_CLEAR   = 2'd0;
	localparam logic [1:0] KIND_APPEND  = 2'd1;
	localparam logic [1:0] KIND_CONSUME = 2'd2;

	typedef struct packed {
		logic                  overflow;
		logic                  found;
		logic [FIELD_BITS-1:0] value;
	} res_t;

endpackage

/* hdl/run_length_skip_decoder.sv */
// run_length_skip_decoder: run table in one synchronous RAM plus head/tail pointers.
// Depends on rlsd_pkg for kind codes, default sizes and the result record.
//
// Timing: a clear or append beat finishes on its accept edge, and its result
// beat is valid in the next cycle if the output register is free. A consume beat
// issues the head read when accepted (or finishes at once on an empty table), then
// walks one run per cycle (one RAM read port). Throughput: one item in flight;
// s_tready is high only in ST_IDLE, and a result parked behind a stalled output
// holds off the input until the output register takes it.
// Reset: arst_n clears pointers, state and output valid at once; the run RAM
// is not cleared (entries at or above the tail are never read).
module run_length_skip_decoder
	import rlsd_pkg::*;
#(
	parameter int MAX_RUNS   = MAX_RUNS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // run_count[31:0], run_value[63:32], step_count[95:64]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value[31:0]
	output logic [1:0]  m_tuser    // found[0], overflow[1]
);

	// Index widths: pointers must hold MAX_RUNS itself, addresses only below it.
	localparam int IW   = $clog2(MAX_RUNS + 1);
	localparam int AW   = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	// Entry: remaining count above the run value.
	localparam int MW   = COUNT_BITS + FIELD_BITS;
	// Arithmetic width wide enough for both a step request and a stored count.
	localparam int WIDE = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;  // take a beat
	localparam logic [1:0] ST_WALK = 2'd1;  // head entry read data is valid
	localparam logic [1:0] ST_HOLD = 2'd2;  // result waits for the output register

	// Unpack the input beat.
	logic [1:0]            kind;
	logic [FIELD_BITS-1:0] run_count;
	logic [FIELD_BITS-1:0] run_value;
	logic [FIELD_BITS-1:0] step_count;

	assign kind       = s_tuser;
	assign run_count  = s_tdata[31:0];
	assign run_value  = s_tdata[63:32];
	assign step_count = s_tdata[95:64];

	// Control state.
	logic [1:0]            state_q, state_d;
	logic [IW-1:0]         head_q, head_d;
	logic [IW-1:0]         used_q, used_d;
	logic [FIELD_BITS-1:0] need_q, need_d;
	res_t                  out_q, pend_q;
	logic                  out_valid_q;

	// Run RAM.
	logic [MW-1:0]         mem [MAX_RUNS];
	logic [MW-1:0]         rd_data_q;
	logic                  rd_en, wr_en;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic [MW-1:0]         wr_data;

	// Finish of the current item.
	logic                  fin;
	res_t                  fin_res;
	logic                  out_free;

	// Datapath helpers.
	logic                  accept;
	logic [IW-1:0]         head_plus;
	logic [WIDE-1:0]       cnt_w, cnt_max, cnt_sat;
	logic [WIDE-1:0]       have_w, need_w, rem_w;
	logic [COUNT_BITS-1:0] rd_count;
	logic [FIELD_BITS-1:0] rd_value;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign head_plus = head_q + IW'(1);

	// Saturate an appended count to what an entry can hold.
	assign cnt_w   = WIDE'(run_count);
	assign cnt_max = WIDE'({COUNT_BITS{1'b1}});
	assign cnt_sat = (cnt_w > cnt_max) ? cnt_max : cnt_w;

	assign rd_count = rd_data_q[MW-1:FIELD_BITS];
	assign rd_value = rd_data_q[FIELD_BITS-1:0];
	assign have_w   = WIDE'(rd_count);
	assign need_w   = WIDE'(need_q);
	assign rem_w    = have_w - need_w;

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		used_d  = used_q;
		need_d  = need_q;
		fin     = 1'b0;
		fin_res = '0;
		rd_en   = 1'b0;
		rd_addr = head_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = used_q[AW-1:0];
		wr_data = {COUNT_BITS'(cnt_sat), run_value};

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_CLEAR: begin
							head_d = '0;
							used_d = '0;
							fin    = 1'b1;
						end
						KIND_APPEND: begin
							fin = 1'b1;
							// Drop zero-count runs silently; flag a full table.
							if (run_count != '0) begin
								if (used_q == IW'(MAX_RUNS)) begin
									fin_res.overflow = 1'b1;
								end else begin
									wr_en  = 1'b1;
									used_d = used_q + IW'(1);
								end
							end
						end
						KIND_CONSUME: begin
							need_d = step_count;
							if (head_q < used_q) begin
								// Issue the head read; data arrives in ST_WALK.
								rd_en   = 1'b1;
								state_d = ST_WALK;
							end else begin
								fin = 1'b1;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_WALK: begin
				wr_addr = head_q[AW-1:0];
				if (have_w >= need_w) begin
					// The request ends in this run: write back what remains.
					wr_en         = 1'b1;
					wr_data       = {COUNT_BITS'(rem_w), rd_value};
					fin           = 1'b1;
					fin_res.found = 1'b1;
					fin_res.value = rd_value;
					if (rem_w == '0) begin
						head_d = head_plus;
					end
				end else begin
					// Skip the whole run; the drained entry is never read again.
					need_d = FIELD_BITS'(need_w - have_w);
					head_d = head_plus;
					if (head_plus < used_q) begin
						rd_en   = 1'b1;
						rd_addr = head_plus[AW-1:0];
					end else begin
						fin = 1'b1;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Park the result when the output register is still occupied.
		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_HOLD;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			used_q  <= used_d;
			if (fin && out_free) begin
				out_valid_q <= 1'b1;
			end else if (state_q == ST_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		need_q <= need_d;
		if (fin && out_free) begin
			out_q <= fin_res;
		end else if (state_q == ST_HOLD && out_free) begin
			out_q <= pend_q;
		end
		if (fin && !out_free) begin
			pend_q <= fin_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.value;
	assign m_tuser  = {out_q.overflow, out_q.found};

endmodule

/* test/run_length_skip_decoder_tb.sv */
`timescale 1ns / 100ps
// run_length_skip_decoder_tb: self-checking bench for the run-length skip decoder.
// Drives clear, append and consume beats and predicts every result beat.
// Depends on rlsd_pkg and run_length_skip_decoder only.
module run_length_skip_decoder_tb;
	import rlsd_pkg::*;

	localparam int RANDOM_ITEMS  = 750;
	localparam int QUIET_ITEMS   = 100;	// last stretch runs with no idling
	localparam int LONG_HOLD     = 300;	// receiver hold-off, in cycles
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 4000;	// cycles with no beat on either side
	localparam int RUN_AW        = $clog2(MAX_RUNS_DEF);

	// Tracks the run table and owes one result per accepted item.
	class run_table_tracker;
		bit [31:0]   run_value_mem [MAX_RUNS_DEF];
		bit [31:0]   run_count_mem [MAX_RUNS_DEF];
		int unsigned head_idx;
		int unsigned used_cnt;
		res_t        pending_results [$];
		int unsigned error_cnt;

		function void note_item(logic [1:0] kind, logic [95:0] data);
			res_t      r;
			bit [31:0] rc;
			bit [31:0] rv;
			bit [31:0] need;
			bit        done;
			r    = '0;
			rc   = data[31:0];
			rv   = data[63:32];
			need = data[95:64];
			done = 1'b0;
			case (kind)
			KIND_CLEAR: begin
				head_idx = 0;
				used_cnt = 0;
			end
			KIND_APPEND: begin
				// zero-count runs are dropped without flagging overflow
				if (rc != 0) begin
					if (used_cnt >= MAX_RUNS_DEF) begin
						r.overflow = 1'b1;
					end else begin
						run_count_mem[used_cnt[RUN_AW-1:0]] = rc;
						run_value_mem[used_cnt[RUN_AW-1:0]] = rv;
						used_cnt++;
					end
				end
			end
			KIND_CONSUME: begin
				// walk runs from the head until the request is covered
				while (!done && head_idx < used_cnt) begin
					if (run_count_mem[head_idx[RUN_AW-1:0]] >= need) begin
						r.value = run_value_mem[head_idx[RUN_AW-1:0]];
						r.found = 1'b1;
						run_count_mem[head_idx[RUN_AW-1:0]] -= need;
						if (run_count_mem[head_idx[RUN_AW-1:0]] == 0)
							head_idx++;
						done = 1'b1;
					end else begin
						need -= run_count_mem[head_idx[RUN_AW-1:0]];
						run_count_mem[head_idx[RUN_AW-1:0]] = 0;
						head_idx++;
					end
				end
			end
			default: ;
			endcase
			pending_results = {pending_results, r};
		endfunction

		function void check_result(logic [31:0] data, logic [1:0] user);
			res_t want;
			if (pending_results.size() == 0) begin
				$error("result beat with no item pending: value %h found %b overflow %b",
					data, user[0], user[1]);
				error_cnt++;
				return;
			end
			want = pending_results.pop_front();
			if (data !== want.value) begin
				$error("value: expected %h, actual %h", want.value, data);
				error_cnt++;
			end
			if (user[0] !== want.found) begin
				$error("found: expected %b, actual %b", want.found, user[0]);
				error_cnt++;
			end
			if (user[1] !== want.overflow) begin
				$error("overflow: expected %b, actual %b", want.overflow, user[1]);
				error_cnt++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;	// run_count[31:0], run_value[63:32], step_count[95:64]
	logic [1:0]  s_tuser = '0;	// kind[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [31:0] m_tdata;	// value[31:0]
	logic [1:0]  m_tuser;	// found[0], overflow[1]

	run_table_tracker tracker = new;
	bit          quiet_tail = 1'b0;
	bit          hold_off_req = 1'b0;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;

	run_length_skip_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Note accepted items first, then check results seen on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata, m_tuser);
		end
	end

	// End the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		bit hold_taken;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one beat, maybe after an idle burst, and hold it until accepted.
	task automatic send_item(logic [1:0] kind, logic [31:0] rc, logic [31:0] rv,
			logic [31:0] step);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {step, rv, rc};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	function automatic logic [31:0] nonzero_word();
		logic [31:0] w;
		w = $urandom;
		return (w == 0) ? 32'd1 : w;
	endfunction

	// Unused fields carry random junk so every bit toggles.
	task automatic clear_table();
		send_item(KIND_CLEAR, $urandom, $urandom, nonzero_word());
	endtask

	task automatic append_run(logic [31:0] rc, logic [31:0] rv);
		send_item(KIND_APPEND, rc, rv, nonzero_word());
	endtask

	task automatic consume(logic [31:0] step);
		send_item(KIND_CONSUME, $urandom, $urandom, step);
	endtask

	// Mostly short runs, with zero and huge counts now and then.
	function automatic logic [31:0] pick_run_count();
		case ($urandom_range(0, 9))
		0: return 32'd0;
		1: return $urandom;
		2: return 32'hFFFF_FFFF;
		default: return $urandom_range(1, 6);
		endcase
	endfunction

	// Mostly small steps; large ones exhaust the sequence.
	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 9))
		0: return nonzero_word();
		1: return 32'hFFFF_FFFF;
		default: return $urandom_range(1, 8);
		endcase
	endfunction

	// Wait until every owed result has arrived; the caller drops valid first.
	task automatic wait_all_results();
		do @(posedge clk); while (tracker.pending_results.size() != 0);
	endtask

	task automatic mixed_sequence();
		if ($urandom_range(0, 2) == 0)
			clear_table();
		repeat ($urandom_range(3, 12)) begin
			if ($urandom_range(0, 1))
				append_run(pick_run_count(), $urandom);
			else
				consume(pick_step());
		end
	endtask

	// Fill the table past capacity, then drain it in one long walk.
	task automatic fill_table();
		int unsigned filled;
		logic [31:0] rc;
		filled = 0;
		clear_table();
		while (filled < MAX_RUNS_DEF + 4) begin
			rc = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1, 3);
			if (rc != 0)
				filled++;
			append_run(rc, $urandom);
		end
		append_run(32'd0, $urandom);	// zero count on a full table: no overflow
		consume($urandom_range(1, 4));
		consume($urandom_range(1, 4));
		consume(32'hFFFF_FFFF);
		append_run(32'd5, $urandom);	// still full until cleared
		clear_table();
	endtask

	initial begin
		int unsigned target;
		bit          fill_done;
		bit          hold_done;
		fill_done = 1'b0;
		hold_done = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, zero and extreme counts, crossing and exhaustion
		consume(32'd1);
		append_run(32'd0, 32'hDEAD_BEEF);
		append_run(32'd1, 32'h0000_0000);
		append_run(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		append_run(32'd3, 32'hA5A5_5A5A);
		consume(32'd1);
		consume(32'hFFFF_FFFF);
		consume(32'd2);
		consume(32'd5);
		consume(32'd1);
		clear_table();
		append_run(32'd2, 32'd7);
		append_run(32'd5, 32'd9);
		consume(32'd4);
		clear_table();
		consume(32'd1);
		append_run(32'd1, 32'h8000_0001);
		consume(32'd1);
		append_run(32'd4, 32'h1234_5678);
		consume(32'd3);
		consume(32'd2);
		s_tvalid <= 1'b0;
		wait_all_results();

		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			if (items_sent + QUIET_ITEMS >= target)
				quiet_tail = 1'b1;
			if (!hold_done && items_sent + RANDOM_ITEMS >= target + 30) begin
				// keep offering beats while the receiver holds off
				hold_off_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!fill_done && items_sent + RANDOM_ITEMS >= target + 80) begin
				fill_table();
				fill_done = 1'b1;
				s_tvalid <= 1'b0;
				wait_all_results();
			end else if ($urandom_range(0, 7) == 0) begin
				send_item(2'($urandom_range(KIND_CLEAR, KIND_CONSUME)), $urandom, $urandom,
					nonzero_word());
			end else begin
				mixed_sequence();
			end
		end

		s_tvalid <= 1'b0;
		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.pending_results.size() != 0) begin
			$error("%0d result beat(s) never arrived", tracker.pending_results.size());
			tracker.error_cnt++;
		end
		if (tracker.error_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hdl/rlsd_pkg.sv
hdl/run_length_skip_decoder.sv
test/run_length_skip_decoder_tb.sv
